[hdl/egcd_pkg.sv]
// Shared types and constants for the extended GCD block.
`timescale 1ns / 1ps

package egcd_pkg;

   localparam int WORD_BITS_DEFAULT = 32;

   // Sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } state_type;

   // Status from the serial divide/accumulate unit
   typedef struct packed {
      logic busy;
      logic done;
   } step_stat_type;

endpackage

[hdl/egcd_step.sv]
// Serial divider with two shift-add accumulators for the quotient times each coefficient.
`timescale 1ns / 1ps

module egcd_step #(
   parameter int WORD_BITS = egcd_pkg::WORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] dividend,
   input  logic signed [WORD_BITS-1:0] divisor,
   input  logic signed [WORD_BITS-1:0] coef_x,
   input  logic signed [WORD_BITS-1:0] coef_y,
   output logic        [WORD_BITS-1:0] rem_mag,
   output logic        [WORD_BITS-1:0] prod_x,
   output logic        [WORD_BITS-1:0] prod_y,
   output egcd_pkg::step_stat_type     stat
);

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] dvd_ff, dvd_in;
   logic [WORD_BITS-1:0] mb_ff, mb_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] px_ff, px_in;
   logic [WORD_BITS-1:0] py_ff, py_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [WORD_BITS-1:0] shifted;
   logic                 q_bit;
   logic                 last;

   // Remainder stays below the divisor magnitude (at most 2^(W-1)), so the
   // shifted partial remainder fits in W bits.
   assign shifted = {rem_ff[WORD_BITS-2:0], dvd_ff[WORD_BITS-1]};
   assign q_bit   = (shifted >= mb_ff);
   assign last    = (cnt_ff == CNT_BITS'(1));

   always_comb begin
      dvd_in  = dvd_ff;
      mb_in   = mb_ff;
      rem_in  = rem_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
         mb_in   = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
         rem_in  = '0;
         px_in   = '0;
         py_in   = '0;
         cnt_in  = CNT_BITS'(WORD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WORD_BITS-2:0], 1'b0};
         rem_in = q_bit ? (shifted - mb_ff) : shifted;
         // Horner form: quotient bits arrive MSB first
         px_in  = {px_ff[WORD_BITS-2:0], 1'b0} + (q_bit ? coef_x : '0);
         py_in  = {py_ff[WORD_BITS-2:0], 1'b0} + (q_bit ? coef_y : '0);
         cnt_in = cnt_ff - 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      mb_ff  <= mb_in;
      rem_ff <= rem_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rem_mag   = rem_ff;
   assign prod_x    = px_ff;
   assign prod_y    = py_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hdl/extended_gcd_bezout.sv]
// Extended Euclidean algorithm: g, x, y with a*x + b*y = g, truncating division.
//
// Input channel req_ (valid/ready) carries operand_a and operand_b; result
// channel rsp_ (valid/ready) carries divisor_g, coef_x and coef_y.
// One transaction at a time: req_ready is high only while the block is idle.
// Each quotient step runs a bit-serial restoring divider, which also
// accumulates the quotient times both current coefficients; the loop test
// in the check state runs before each step. For 32-bit operands the
// number of quotient steps is at most about 48. A zero b skips the divider
// and gives (a, 1, 0) from the check state, without a quotient step.
// The result sits in output registers with rsp_valid high until taken; while
// the receiver stalls the block holds it and accepts nothing new.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
// divider's counter and status and drops any transaction in flight; the datapath registers are not reset.
// Values are WORD_BITS-bit two's complement; quotients, remainders and
// coefficients wrap modulo 2^WORD_BITS.
`timescale 1ns / 1ps

module extended_gcd_bezout #(
   parameter int WORD_BITS = egcd_pkg::WORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [WORD_BITS-1:0] req_operand_a,
   input  logic signed [WORD_BITS-1:0] req_operand_b,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_divisor_g,
   output logic signed [WORD_BITS-1:0] rsp_coef_x,
   output logic signed [WORD_BITS-1:0] rsp_coef_y
);

   egcd_pkg::state_type     state_ff, state_in;
   egcd_pkg::step_stat_type stat;

   logic [WORD_BITS-1:0] r0_ff, r0_in;
   logic [WORD_BITS-1:0] r1_ff, r1_in;
   logic [WORD_BITS-1:0] x0_ff, x0_in;
   logic [WORD_BITS-1:0] x1_ff, x1_in;
   logic [WORD_BITS-1:0] y0_ff, y0_in;
   logic [WORD_BITS-1:0] y1_ff, y1_in;

   logic [WORD_BITS-1:0] rem_mag;
   logic [WORD_BITS-1:0] prod_x;
   logic [WORD_BITS-1:0] prod_y;
   logic                 step_start;
   logic                 q_neg;
   logic                 r1_zero;

   assign q_neg   = r0_ff[WORD_BITS-1] ^ r1_ff[WORD_BITS-1];
   assign r1_zero = (r1_ff == '0);

   egcd_step #(
      .WORD_BITS (WORD_BITS)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .start    (step_start),
      .dividend (r0_ff),
      .divisor  (r1_ff),
      .coef_x   (x1_ff),
      .coef_y   (y1_ff),
      .rem_mag  (rem_mag),
      .prod_x   (prod_x),
      .prod_y   (prod_y),
      .stat     (stat)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         egcd_pkg::ST_IDLE: begin
            if (req_valid) state_in = egcd_pkg::ST_CHECK;
         end
         egcd_pkg::ST_CHECK: begin
            state_in = r1_zero ? egcd_pkg::ST_DONE : egcd_pkg::ST_DIV;
         end
         egcd_pkg::ST_DIV: begin
            if (stat.done) state_in = egcd_pkg::ST_CHECK;
         end
         egcd_pkg::ST_DONE: begin
            if (rsp_ready) state_in = egcd_pkg::ST_IDLE;
         end
         default: state_in = egcd_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      step_start = 1'b0;
      case (state_ff)
         egcd_pkg::ST_IDLE:  req_ready  = 1'b1;
         egcd_pkg::ST_CHECK: step_start = !r1_zero;
         egcd_pkg::ST_DIV:   step_start = 1'b0;
         egcd_pkg::ST_DONE:  rsp_valid  = 1'b1;
         default:            req_ready  = 1'b0;
      endcase
   end

   // Remainder pair and coefficient pairs
   always_comb begin
      r0_in = r0_ff;
      r1_in = r1_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      y0_in = y0_ff;
      y1_in = y1_ff;
      if (req_valid && req_ready) begin
         r0_in = req_operand_a;
         r1_in = req_operand_b;
         x0_in = WORD_BITS'(1);
         x1_in = '0;
         y0_in = '0;
         y1_in = WORD_BITS'(1);
      end else if (state_ff == egcd_pkg::ST_DIV && stat.done) begin
         r0_in = r1_ff;
         // remainder takes the sign of the dividend
         r1_in = r0_ff[WORD_BITS-1] ? (~rem_mag + 1'b1) : rem_mag;
         x0_in = x1_ff;
         x1_in = q_neg ? (x0_ff + prod_x) : (x0_ff - prod_x);
         y0_in = y1_ff;
         y1_in = q_neg ? (y0_ff + prod_y) : (y0_ff - prod_y);
      end
   end

   always_ff @(posedge clock) begin
      r0_ff <= r0_in;
      r1_ff <= r1_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      y0_ff <= y0_in;
      y1_ff <= y1_in;
      if (reset) begin
         state_ff <= egcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_divisor_g = r0_ff;
   assign rsp_coef_x    = x0_ff;
   assign rsp_coef_y    = y0_ff;

`ifndef SYNTHESIS
   // the divider only finishes while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> state_ff == egcd_pkg::ST_DIV)
      else $error("divide step finished outside the divide state");

   // loop ends when the running remainder reaches zero
   a_exit_on_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == egcd_pkg::ST_CHECK && r1_zero) |=> rsp_valid)
      else $error("zero remainder did not end the loop");

   // a stalled result keeps its value
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_divisor_g) && $stable(rsp_coef_x)
          && $stable(rsp_coef_y)))
      else $error("stalled result changed");

   // no new transaction and no result while the unit is working
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_ready && !rsp_valid)
      else $error("channel active while divider busy");
`endif

endmodule
